// ===== rtl/core/gcs_pkg.sv =====
// gcs_pkg: widths, types and register codes shared by the gradient center score block
// no dependencies; imported by gcs_lane, gcs_merge and gradient_center_score
package gcs_pkg;

    localparam int LANES      = 4;
    localparam int COORD_BITS = 10;

    localparam int POS_W  = 2 * COORD_BITS;
    localparam int Q_W    = 16;
    localparam int GRAD_W = 2 * Q_W;
    localparam int D_W    = COORD_BITS + 1;          // signed displacement
    localparam int DOT_W  = D_W + Q_W;               // signed dot product
    localparam int P_W    = DOT_W - 1;               // positive dot magnitude
    localparam int NUM_W  = 2 * P_W;                 // dot squared
    localparam int D2_W   = 2 * COORD_BITS + 1;      // squared length
    localparam int SQ_W   = 2 * D_W;                 // one squared displacement
    localparam int TERM_W = 2 * Q_W;                 // lane term, at most 2^31
    localparam int CNT_W  = $clog2(TERM_W);
    localparam int SUM_W  = TERM_W + $clog2(LANES);
    localparam int ACC_W  = 48;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COORD_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 1'b1;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    typedef logic [TERM_W-1:0] term_t;
    typedef logic [COORD_BITS-1:0] coord_t;

endpackage

// ===== rtl/core/gcs_lane.sv =====
// gcs_lane: one scoring lane, displacement, dot product, square and radix-2 divide
// depends on gcs_pkg
module gcs_lane
    import gcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [POS_W-1:0]  pos,
    input  logic [GRAD_W-1:0] grad,
    input  coord_t            center_x,
    input  coord_t            center_y,
    output term_t             term,
    output logic              done
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_PROD = 4'b0010,
        L_SQR  = 4'b0100,
        L_DIV  = 4'b1000
    } lane_state_t;

    lane_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic done_reg, done_next;

    logic signed [D_W-1:0]   dx_reg, dy_reg;
    logic signed [Q_W-1:0]   gx_reg, gy_reg;
    logic signed [DOT_W-1:0] px, py, dot;
    logic signed [SQ_W-1:0]  sqx, sqy;
    logic [D2_W-1:0]         d2_c, d2_reg;
    logic [P_W-1:0]          p_reg;
    logic                    dot_pos_reg;
    logic                    zero_reg;
    logic [NUM_W-1:0]        num;
    logic [D2_W-1:0]         rem_reg;
    term_t                   quo_reg;
    logic [D2_W:0]           trial;
    logic                    ge;

    assign px   = dx_reg * gx_reg;
    assign py   = dy_reg * gy_reg;
    assign dot  = px + py;
    assign sqx  = dx_reg * dx_reg;
    assign sqy  = dy_reg * dy_reg;
    assign d2_c = D2_W'($unsigned(sqx)) + D2_W'($unsigned(sqy));
    assign num  = p_reg * p_reg;

    // one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[TERM_W-1]};
    assign ge    = trial >= {1'b0, d2_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    state_next = L_PROD;
                end
            end
            L_PROD:
            begin
                state_next = L_SQR;
            end
            L_SQR:
            begin
                state_next = L_DIV;
                cnt_next   = '0;
            end
            L_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TERM_W - 1))
                begin
                    state_next = L_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && start)
        begin
            dx_reg <= $signed({1'b0, pos[COORD_BITS-1:0]} - {1'b0, center_x});
            dy_reg <= $signed({1'b0, pos[POS_W-1:COORD_BITS]} - {1'b0, center_y});
            gx_reg <= $signed(grad[Q_W-1:0]);
            gy_reg <= $signed(grad[GRAD_W-1:Q_W]);
        end
        if (state_reg == L_PROD)
        begin
            p_reg       <= dot[P_W-1:0];
            dot_pos_reg <= !dot[DOT_W-1] && (dot != '0);
            d2_reg      <= d2_c;
        end
        if (state_reg == L_SQR)
        begin
            zero_reg <= !dot_pos_reg || (d2_reg == '0);
            rem_reg  <= D2_W'(num[NUM_W-1:TERM_W]);
            quo_reg  <= num[TERM_W-1:0];
        end
        if (state_reg == L_DIV)
        begin
            rem_reg <= ge ? D2_W'(trial - {1'b0, d2_reg}) : D2_W'(trial);
            quo_reg <= {quo_reg[TERM_W-2:0], ge};
        end
    end

    assign term = zero_reg ? '0 : quo_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/gcs_merge.sv =====
// gcs_merge: sums the lane terms, saturating accumulator and result register
// depends on gcs_pkg
module gcs_merge
    import gcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              terms_valid,
    input  term_t             terms [LANES],
    input  logic              last,
    output logic              commit,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ACC_W-1:0]  score,
    output logic              saturated
);

    logic             sum_valid_reg;
    logic [SUM_W-1:0] sum_reg, sum_c;
    logic             last_reg;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             clip_reg, clip_next;
    logic [ACC_W:0]   wide;
    logic             over;
    logic             out_valid_reg;
    logic [ACC_W-1:0] score_reg;
    logic             sat_reg;
    logic             load_out;

    always_comb
    begin
        sum_c = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sum_c = sum_c + SUM_W'(terms[i]);
        end
    end

    assign wide      = {1'b0, acc_reg} + (ACC_W + 1)'(sum_reg);
    assign over      = wide[ACC_W];
    assign acc_next  = over ? ACC_MAX : wide[ACC_W-1:0];
    assign clip_next = clip_reg || over;

    // a final group waits while the previous score is still unclaimed
    assign commit   = sum_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign load_out = commit && last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (terms_valid)
            begin
                sum_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                sum_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                acc_reg  <= last_reg ? '0 : acc_next;
                clip_reg <= last_reg ? 1'b0 : clip_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (terms_valid)
        begin
            sum_reg  <= sum_c;
            last_reg <= last;
        end
        if (load_out)
        begin
            score_reg <= acc_next;
            sat_reg   <= clip_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign score     = score_reg;
    assign saturated = sat_reg;

endmodule

// ===== rtl/core/gradient_center_score.sv =====
// gradient_center_score: top level, four scoring lanes feeding one merge stage
// depends on gcs_pkg, gcs_lane and gcs_merge
//
//  channel   signals                        direction  transfer when
//  in        in_valid in_stall pos/grad/last  sink       in_valid && !in_stall
//  out       out_valid out_stall score/sat    source     out_valid && !out_stall
//  cfg       cfg_wr_en cfg_index cfg_data     sink       cfg_wr_en
//
// each group passes through these steps after its transfer: the transfer edge
// registers the displacement, then the dot product and the square are registered,
// the one-bit-per-cycle divider runs in every lane, the lane sum is registered and
// the saturating add commits it; no new group is taken before that commit
// in_stall is high from a transfer until that group is accumulated
// a final group is held in the merge stage while the previous score is unclaimed
// reset clears control state, the center registers and the accumulator
module gradient_center_score
    import gcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [POS_W-1:0]      pos_lane0,
    input  logic [POS_W-1:0]      pos_lane1,
    input  logic [POS_W-1:0]      pos_lane2,
    input  logic [POS_W-1:0]      pos_lane3,
    input  logic [GRAD_W-1:0]     grad_lane0,
    input  logic [GRAD_W-1:0]     grad_lane1,
    input  logic [GRAD_W-1:0]     grad_lane2,
    input  logic [GRAD_W-1:0]     grad_lane3,
    input  logic                  last_group,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ACC_W-1:0]      score,
    output logic                  saturated
);

    coord_t center_x_reg, center_y_reg;
    logic   busy_reg, busy_next;
    logic   last_reg;
    logic   accept;
    logic   commit;

    logic [POS_W-1:0]  pos_arr  [LANES];
    logic [GRAD_W-1:0] grad_arr [LANES];
    term_t             terms    [LANES];
    logic [LANES-1:0]  lane_done;

    assign pos_arr[0]  = pos_lane0;
    assign pos_arr[1]  = pos_lane1;
    assign pos_arr[2]  = pos_lane2;
    assign pos_arr[3]  = pos_lane3;
    assign grad_arr[0] = grad_lane0;
    assign grad_arr[1] = grad_lane1;
    assign grad_arr[2] = grad_lane2;
    assign grad_arr[3] = grad_lane3;

    // one group in flight at a time
    assign in_stall  = busy_reg;
    assign accept    = in_valid && !in_stall;
    assign busy_next = accept ? 1'b1 : (commit ? 1'b0 : busy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_CENTER_X: center_x_reg <= cfg_data;
                    CFG_CENTER_Y: center_y_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    // end-of-run mark rides along with the group
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last_group;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        gcs_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (accept),
            .pos      (pos_arr[i]),
            .grad     (grad_arr[i]),
            .center_x (center_x_reg),
            .center_y (center_y_reg),
            .term     (terms[i]),
            .done     (lane_done[i])
        );
    end

    // all lanes run in lockstep, so their done pulses coincide
    gcs_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .terms_valid (&lane_done),
        .terms       (terms),
        .last        (last_reg),
        .commit      (commit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .score       (score),
        .saturated   (saturated)
    );

endmodule
